### hdl/drmb_pkg.sv
// Shared types, constants and helper functions for the dual region mean brightness block.
// Used by every module of the block and by the channel interfaces.
`default_nettype none

package drmb_pkg;

    // Field and register widths.
    localparam int COORD_W     = 10;
    localparam int REG_W       = 11;
    localparam int CH_W        = 8;
    localparam int NUM_REGS    = 8;
    localparam int RIDX_W      = $clog2(NUM_REGS);
    localparam int CFG_IDX_W   = 4;
    localparam int VAL_W       = 10;
    localparam int SUM_W       = 30;
    localparam int CMP_W       = 13;
    localparam int DIV_W       = 24;
    localparam int CNT_W       = $clog2(SUM_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CH_W-1:0]  MEAN_MAX = {CH_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [RIDX_W-1:0] {
        REG_LEFT_X_LOW,
        REG_LEFT_X_HIGH,
        REG_LEFT_Y_LOW,
        REG_LEFT_Y_HIGH,
        REG_RIGHT_X_LOW,
        REG_RIGHT_X_HIGH,
        REG_RIGHT_Y_LOW,
        REG_RIGHT_Y_HIGH
    } t_reg_idx;

    typedef struct packed {
        logic [REG_W-1:0] x_low;
        logic [REG_W-1:0] x_high;
        logic [REG_W-1:0] y_low;
        logic [REG_W-1:0] y_high;
    } t_rect;

    // One entry of the queue between the front and the back end.
    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             frame_end;
        logic             left_ok;
        logic             right_ok;
        logic [SUM_W-1:0] left_sum;
        logic [SUM_W-1:0] right_sum;
        logic [REG_W-1:0] left_dx;
        logic [REG_W-1:0] left_dy;
        logic [REG_W-1:0] right_dx;
        logic [REG_W-1:0] right_dy;
    } t_job;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] left_mean;
        logic [CH_W-1:0] right_mean;
        logic            means_valid;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } t_back_state;

    // A rectangle is usable only if it is non-empty and lies inside the frame.
    function automatic logic rect_valid(t_rect r, logic [CMP_W-1:0] fw,
                                        logic [CMP_W-1:0] fh);
        logic [CMP_W-1:0] xl;
        logic [CMP_W-1:0] xh;
        logic [CMP_W-1:0] yl;
        logic [CMP_W-1:0] yh;
        xl = CMP_W'(r.x_low);
        xh = CMP_W'(r.x_high);
        yl = CMP_W'(r.y_low);
        yh = CMP_W'(r.y_high);
        return !((xl >= xh) || (yl >= yh) || (xl >= fw) || (yl >= fh) ||
                 (xh > fw) || (yh >= fh));
    endfunction

    function automatic logic rect_inside(t_rect r, logic [CMP_W-1:0] x,
                                         logic [CMP_W-1:0] y);
        return (x >= CMP_W'(r.x_low)) && (x < CMP_W'(r.x_high)) &&
               (y >= CMP_W'(r.y_low)) && (y < CMP_W'(r.y_high));
    endfunction

    function automatic logic rect_border(t_rect r, logic [CMP_W-1:0] x,
                                         logic [CMP_W-1:0] y, logic [CMP_W-1:0] bs);
        return (x < CMP_W'(r.x_low) + bs) || (x + bs >= CMP_W'(r.x_high)) ||
               (y < CMP_W'(r.y_low) + bs) || (y + bs >= CMP_W'(r.y_high));
    endfunction

    // Adds a pixel value to a running sum, clamping at the largest sum.
    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] sum,
                                                 logic [VAL_W-1:0] val);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + (SUM_W+1)'(val);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/drmb_ifs.sv
// Channel interfaces of the block: configuration writes, pixel requests and results.
// Depends on drmb_pkg for the field widths.
`default_nettype none

interface drmb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [drmb_pkg::CFG_IDX_W-1:0] index;
    logic [drmb_pkg::REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface drmb_pix_if;
    logic                         valid;
    logic                         ready;
    logic [drmb_pkg::COORD_W-1:0] col;
    logic [drmb_pkg::COORD_W-1:0] row;
    logic [drmb_pkg::CH_W-1:0]    red_in;
    logic [drmb_pkg::CH_W-1:0]    green_in;
    logic [drmb_pkg::CH_W-1:0]    blue_in;
    logic                         frame_end;

    modport source (output valid, output col, output row, output red_in,
                    output green_in, output blue_in, output frame_end, input ready);
    modport sink   (input valid, input col, input row, input red_in,
                    input green_in, input blue_in, input frame_end, output ready);
endinterface

interface drmb_res_if;
    logic                      valid;
    logic                      ready;
    logic [drmb_pkg::CH_W-1:0] red_out;
    logic [drmb_pkg::CH_W-1:0] green_out;
    logic [drmb_pkg::CH_W-1:0] blue_out;
    logic [drmb_pkg::CH_W-1:0] left_mean;
    logic [drmb_pkg::CH_W-1:0] right_mean;
    logic                      means_valid;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output left_mean, output right_mean, output means_valid,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input left_mean, input right_mean, input means_valid,
                    output ready);
endinterface

`default_nettype wire

### hdl/drmb_front.sv
// Front end: holds the configuration registers, masks rectangle borders and keeps both sums.
// Depends on drmb_pkg and the channel interfaces in drmb_ifs.sv.
`default_nettype none

module drmb_front #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024,
    parameter int BORDER_SIZE  = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    drmb_cfg_if.sink       i_cfg,
    drmb_pix_if.sink       i_pix,
    input  logic           i_full,
    output logic           o_push,
    output drmb_pkg::t_job o_job
);
    import drmb_pkg::*;

    localparam logic [CMP_W-1:0] FW = CMP_W'(FRAME_WIDTH);
    localparam logic [CMP_W-1:0] FH = CMP_W'(FRAME_HEIGHT);
    localparam logic [CMP_W-1:0] BS = CMP_W'(BORDER_SIZE);

    logic [REG_W-1:0] r_cfg [NUM_REGS];
    logic [SUM_W-1:0] r_left_sum;
    logic [SUM_W-1:0] r_right_sum;
    logic [SUM_W-1:0] n_left_sum;
    logic [SUM_W-1:0] n_right_sum;

    t_rect            w_left;
    t_rect            w_right;
    logic             w_left_ok;
    logic             w_right_ok;
    logic [CMP_W-1:0] w_x;
    logic [CMP_W-1:0] w_y;
    logic [VAL_W-1:0] w_val_l;
    logic [VAL_W-1:0] w_val_r;
    logic             w_in_l;
    logic             w_in_r;
    logic             w_bd_l;
    logic             w_bd_r;
    logic [CH_W-1:0]  w_red1;
    logic [CH_W-1:0]  w_green1;
    logic [CH_W-1:0]  w_blue1;

    // Configuration writes are always taken; indexes past the list are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg.valid && (i_cfg.index < CFG_IDX_W'(NUM_REGS))) begin
            r_cfg[i_cfg.index[RIDX_W-1:0]] <= i_cfg.data;
        end
    end

    always_comb begin
        w_left = '{x_low:  r_cfg[REG_LEFT_X_LOW],  x_high: r_cfg[REG_LEFT_X_HIGH],
                   y_low:  r_cfg[REG_LEFT_Y_LOW],  y_high: r_cfg[REG_LEFT_Y_HIGH]};
        w_right = '{x_low: r_cfg[REG_RIGHT_X_LOW], x_high: r_cfg[REG_RIGHT_X_HIGH],
                    y_low: r_cfg[REG_RIGHT_Y_LOW], y_high: r_cfg[REG_RIGHT_Y_HIGH]};
        w_left_ok  = rect_valid(w_left, FW, FH);
        w_right_ok = rect_valid(w_right, FW, FH);
    end

    // Left rectangle first; the right one sees the pixel after the left mask.
    always_comb begin
        w_x      = CMP_W'(i_pix.col);
        w_y      = CMP_W'(i_pix.row);
        w_val_l  = VAL_W'(i_pix.red_in) + VAL_W'(i_pix.green_in) + VAL_W'(i_pix.blue_in);
        w_in_l   = w_left_ok && rect_inside(w_left, w_x, w_y);
        w_bd_l   = w_in_l && rect_border(w_left, w_x, w_y, BS);
        w_red1   = w_bd_l ? '0 : i_pix.red_in;
        w_green1 = w_bd_l ? '0 : i_pix.green_in;
        w_blue1  = w_bd_l ? '0 : i_pix.blue_in;
        w_val_r  = VAL_W'(w_red1) + VAL_W'(w_green1) + VAL_W'(w_blue1);
        w_in_r   = w_right_ok && rect_inside(w_right, w_x, w_y);
        w_bd_r   = w_in_r && rect_border(w_right, w_x, w_y, BS);
    end

    always_comb begin
        n_left_sum  = w_in_l ? sat_add(r_left_sum, w_val_l) : r_left_sum;
        n_right_sum = w_in_r ? sat_add(r_right_sum, w_val_r) : r_right_sum;
    end

    // A pixel enters only when the queue has room.
    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    always_comb begin
        o_job.red       = w_bd_r ? '0 : w_red1;
        o_job.green     = w_bd_r ? '0 : w_green1;
        o_job.blue      = w_bd_r ? '0 : w_blue1;
        o_job.frame_end = i_pix.frame_end;
        o_job.left_ok   = w_left_ok;
        o_job.right_ok  = w_right_ok;
        o_job.left_sum  = n_left_sum;
        o_job.right_sum = n_right_sum;
        o_job.left_dx   = w_left.x_high - w_left.x_low;
        o_job.left_dy   = w_left.y_high - w_left.y_low;
        o_job.right_dx  = w_right.x_high - w_right.x_low;
        o_job.right_dy  = w_right.y_high - w_right.y_low;
    end

    // Sums restart after the frame-end pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_sum  <= '0;
            r_right_sum <= '0;
        end else if (o_push) begin
            r_left_sum  <= i_pix.frame_end ? '0 : n_left_sum;
            r_right_sum <= i_pix.frame_end ? '0 : n_right_sum;
        end
    end

endmodule

`default_nettype wire

### hdl/drmb_queue.sv
// Short first-in first-out queue of pixel jobs between the front and the back end.
// Depends on drmb_pkg for the job type and the depth.
`default_nettype none

module drmb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  drmb_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output drmb_pkg::t_job o_job,
    output logic           o_empty
);
    import drmb_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/drmb_back.sv
// Back end: forwards ordinary pixels and divides both sums on a frame-end pixel.
// Depends on drmb_pkg and the result interface in drmb_ifs.sv.
`default_nettype none

module drmb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  drmb_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    drmb_res_if.source     o_res
);
    import drmb_pkg::*;

    t_back_state      r_state;
    t_back_state      n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_job             r_work;
    t_job             n_work;
    logic [DIV_W-1:0] r_div_l;
    logic [DIV_W-1:0] n_div_l;
    logic [DIV_W-1:0] r_div_r;
    logic [DIV_W-1:0] n_div_r;
    logic [DIV_W-1:0] r_rem_l;
    logic [DIV_W-1:0] n_rem_l;
    logic [DIV_W-1:0] r_rem_r;
    logic [DIV_W-1:0] n_rem_r;
    t_result          r_out;
    t_result          n_out;
    logic             r_out_valid;
    logic             n_out_valid;

    logic               w_out_free;
    logic [2*REG_W-1:0] w_prod_l;
    logic [2*REG_W-1:0] w_prod_r;
    logic [DIV_W:0]     w_sh_l;
    logic [DIV_W:0]     w_sh_r;
    logic               w_ge_l;
    logic               w_ge_r;
    logic [CH_W-1:0]    w_mean_l;
    logic [CH_W-1:0]    w_mean_r;

    assign w_out_free = !r_out_valid || o_res.ready;

    // Area products of both rectangles.
    assign w_prod_l = r_work.left_dx * r_work.left_dy;
    assign w_prod_r = r_work.right_dx * r_work.right_dy;

    // One restoring division step for each rectangle; the quotient shifts into the sum.
    always_comb begin
        w_sh_l = {r_rem_l, r_work.left_sum[SUM_W-1]};
        w_sh_r = {r_rem_r, r_work.right_sum[SUM_W-1]};
        w_ge_l = (w_sh_l >= {1'b0, r_div_l});
        w_ge_r = (w_sh_r >= {1'b0, r_div_r});
    end

    // Clamp the quotients and force zero for an unusable rectangle.
    always_comb begin
        if (!r_work.left_ok) begin
            w_mean_l = '0;
        end else if (|r_work.left_sum[SUM_W-1:CH_W]) begin
            w_mean_l = MEAN_MAX;
        end else begin
            w_mean_l = r_work.left_sum[CH_W-1:0];
        end
        if (!r_work.right_ok) begin
            w_mean_r = '0;
        end else if (|r_work.right_sum[SUM_W-1:CH_W]) begin
            w_mean_r = MEAN_MAX;
        end else begin
            w_mean_r = r_work.right_sum[CH_W-1:0];
        end
    end

    // Sequencer: next state, queue pop and output register loading.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_work      = r_work;
        n_div_l     = r_div_l;
        n_div_r     = r_div_r;
        n_rem_l     = r_rem_l;
        n_rem_r     = r_rem_r;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty && w_out_free) begin
                    o_pop = 1'b1;
                    if (i_job.frame_end) begin
                        n_work  = i_job;
                        n_state = ST_SETUP;
                    end else begin
                        n_out_valid       = 1'b1;
                        n_out.red         = i_job.red;
                        n_out.green       = i_job.green;
                        n_out.blue        = i_job.blue;
                        n_out.left_mean   = '0;
                        n_out.right_mean  = '0;
                        n_out.means_valid = 1'b0;
                    end
                end
            end
            ST_SETUP: begin
                n_div_l = DIV_W'({w_prod_l, 1'b0}) + DIV_W'(w_prod_l);
                n_div_r = DIV_W'({w_prod_r, 1'b0}) + DIV_W'(w_prod_r);
                n_rem_l = '0;
                n_rem_r = '0;
                n_cnt   = CNT_W'(SUM_W - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem_l = w_ge_l ? DIV_W'(w_sh_l - {1'b0, r_div_l}) : DIV_W'(w_sh_l);
                n_rem_r = w_ge_r ? DIV_W'(w_sh_r - {1'b0, r_div_r}) : DIV_W'(w_sh_r);
                n_work.left_sum  = {r_work.left_sum[SUM_W-2:0], w_ge_l};
                n_work.right_sum = {r_work.right_sum[SUM_W-2:0], w_ge_r};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.red         = r_work.red;
                    n_out.green       = r_work.green;
                    n_out.blue        = r_work.blue;
                    n_out.left_mean   = w_mean_l;
                    n_out.right_mean  = w_mean_r;
                    n_out.means_valid = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // Working and output data.
    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_div_l <= n_div_l;
        r_div_r <= n_div_r;
        r_rem_l <= n_rem_l;
        r_rem_r <= n_rem_r;
        r_out   <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.red_out     = r_out.red;
    assign o_res.green_out   = r_out.green;
    assign o_res.blue_out    = r_out.blue;
    assign o_res.left_mean   = r_out.left_mean;
    assign o_res.right_mean  = r_out.right_mean;
    assign o_res.means_valid = r_out.means_valid;

endmodule

`default_nettype wire

### hdl/dual_roi_mean_brightness_top.sv
// Top level of the dual region mean brightness block: front end, job queue, back end.
// Depends on drmb_pkg, drmb_ifs.sv, drmb_front, drmb_queue and drmb_back.
`default_nettype none

// Takes one RGB pixel per clock while the queue has room, with its column, row and a
// frame-end flag, and returns one result per pixel: the channels with rectangle borders
// blanked and, on the frame-end pixel, the mean channel value of each of the two configured
// rectangles. Ordinary pixels flow at one per cycle while results are taken. A frame-end
// pixel holds the back end for the area multiply, 30 steps of the bit-serial divider and
// the result, while the front keeps taking pixels into a four-entry queue until it fills.
// Configuration writes are always ready and take effect on the next pixel.
module dual_roi_mean_brightness_top #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024,
    parameter int BORDER_SIZE  = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drmb_cfg_if.sink   i_cfg,
    drmb_pix_if.sink   i_pix,
    drmb_res_if.source o_res
);
    import drmb_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    drmb_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .BORDER_SIZE  (BORDER_SIZE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_pix   (i_pix),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    drmb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    drmb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### hdl/drmb_checker.sv
// Port-level checks of the dual region mean brightness block, bound to its top level.
// Depends on drmb_pkg for the channel widths.
`default_nettype none

module drmb_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_ready,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input logic                      i_means_valid,
    input logic [drmb_pkg::CH_W-1:0] i_left_mean,
    input logic [drmb_pkg::CH_W-1:0] i_right_mean
);

    // A result that is not taken stays offered.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // Means are reported only on frame-end results.
    a_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_means_valid |-> (i_left_mean == '0) && (i_right_mean == '0))
        else $error("nonzero mean on an ordinary pixel result");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result offered right after reset");

    // Configuration writes never stall.
    a_cfg_ready: assert property (@(posedge i_clk)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind dual_roi_mean_brightness_top drmb_checker u_drmb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_ready   (i_cfg.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_means_valid (o_res.means_valid),
    .i_left_mean   (o_res.left_mean),
    .i_right_mean  (o_res.right_mean)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dual_roi_mean_brightness_top: directed and random pixel streams
// over two programmable rectangles, each result compared against a behavioral prediction.
// Depends on drmb_pkg, the channel interfaces in drmb_ifs.sv and the block's RTL.

module tb;
    import drmb_pkg::*;

    localparam int FRAME_W       = 1024;
    localparam int FRAME_H       = 1024;
    localparam int RIM           = 2;
    localparam int MAX_CYCLES    = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 100;
    localparam int IDLE_PCT      = 31;
    localparam int REPORT_MAX    = 10;
    localparam int RASTER_AREA   = 64;

    logic i_clk;
    logic i_rst_n;

    drmb_cfg_if cfg_ch ();
    drmb_pix_if pix_ch ();
    drmb_res_if res_ch ();

    dual_roi_mean_brightness_top #(
        .FRAME_WIDTH (FRAME_W),
        .FRAME_HEIGHT(FRAME_H),
        .BORDER_SIZE (RIM)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_pix  (pix_ch),
        .o_res  (res_ch)
    );

    // Predicted register contents and running brightness sums.
    logic [REG_W-1:0] roi_regs [NUM_REGS];
    logic [SUM_W-1:0] left_total;
    logic [SUM_W-1:0] right_total;
    t_result          pending_results [$];
    t_result          want;

    bit          gaps_on;
    int unsigned cycle_count;
    int unsigned pixels_sent;
    int unsigned results_seen;
    int unsigned frames_closed;
    int unsigned settings_used;
    int unsigned mismatches;

    // Free-running clock.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // The result side stalls at random while gaps are enabled.
    always @(negedge i_clk) begin
        res_ch.ready <= !(gaps_on && ($urandom_range(99) < IDLE_PCT));
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Result %0d arrived with no prediction waiting.", results_seen);
            end else begin
                want = pending_results.pop_front();
                if (want.red !== res_ch.red_out || want.green !== res_ch.green_out ||
                    want.blue !== res_ch.blue_out || want.left_mean !== res_ch.left_mean ||
                    want.right_mean !== res_ch.right_mean ||
                    want.means_valid !== res_ch.means_valid) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Mismatch on result %0d: expected rgb %0d %0d %0d means %0d %0d flag %0b",
                                 results_seen, want.red, want.green, want.blue,
                                 want.left_mean, want.right_mean, want.means_valid);
                        $display("    got rgb %0d %0d %0d means %0d %0d flag %0b",
                                 res_ch.red_out, res_ch.green_out, res_ch.blue_out,
                                 res_ch.left_mean, res_ch.right_mean, res_ch.means_valid);
                    end
                end
            end
        end
    end

    function automatic t_rect rect_of(int xl, int xh, int yl, int yh);
        t_rect r;
        r.x_low  = REG_W'(xl);
        r.x_high = REG_W'(xh);
        r.y_low  = REG_W'(yl);
        r.y_high = REG_W'(yh);
        return r;
    endfunction

    function automatic t_rect roi_from(int base);
        return rect_of(roi_regs[base], roi_regs[base + 1], roi_regs[base + 2],
                       roi_regs[base + 3]);
    endfunction

    // A rectangle counts only if it is non-empty and fits the frame; the last row is excluded.
    function automatic bit roi_usable(t_rect r);
        int unsigned xl, xh, yl, yh;
        xl = r.x_low;
        xh = r.x_high;
        yl = r.y_low;
        yh = r.y_high;
        if (xl >= xh || yl >= yh) return 1'b0;
        if (xl >= FRAME_W || yl >= FRAME_H || xh > FRAME_W || yh >= FRAME_H) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit roi_holds(t_rect r, int unsigned x, int unsigned y);
        return x >= r.x_low && x < r.x_high && y >= r.y_low && y < r.y_high;
    endfunction

    function automatic bit roi_rim(t_rect r, int unsigned x, int unsigned y);
        int unsigned xl, xh, yl, yh;
        xl = r.x_low;
        xh = r.x_high;
        yl = r.y_low;
        yh = r.y_high;
        return (x < xl + RIM) || (x + RIM >= xh) || (y < yl + RIM) || (y + RIM >= yh);
    endfunction

    function automatic logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] sum, int unsigned val);
        longint unsigned t;
        t = longint'(sum) + val;
        if (t > longint'(SUM_MAX)) return SUM_MAX;
        return SUM_W'(t);
    endfunction

    function automatic logic [CH_W-1:0] roi_mean(t_rect r, logic [SUM_W-1:0] sum);
        longint unsigned area, q;
        if (!roi_usable(r)) return '0;
        area = longint'(r.x_high - r.x_low) * longint'(r.y_high - r.y_low) * 3;
        q = longint'(sum) / area;
        return (q > MEAN_MAX) ? MEAN_MAX : CH_W'(q);
    endfunction

    // Work out the result of one accepted pixel and update the sums.
    task automatic predict_pixel(input int unsigned x, input int unsigned y,
                                 input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                 input logic [CH_W-1:0] b, input logic fe);
        t_rect       lr;
        t_rect       rr;
        t_result     res;
        int unsigned level;
        lr = roi_from(REG_LEFT_X_LOW);
        rr = roi_from(REG_RIGHT_X_LOW);
        res = '0;
        res.red = r;
        res.green = g;
        res.blue = b;
        // The right rectangle sees the pixel after the left one has blanked it.
        if (roi_usable(lr) && roi_holds(lr, x, y)) begin
            level = res.red;
            level += res.green;
            level += res.blue;
            left_total = add_clamped(left_total, level);
            if (roi_rim(lr, x, y)) begin
                res.red = '0;
                res.green = '0;
                res.blue = '0;
            end
        end
        if (roi_usable(rr) && roi_holds(rr, x, y)) begin
            level = res.red;
            level += res.green;
            level += res.blue;
            right_total = add_clamped(right_total, level);
            if (roi_rim(rr, x, y)) begin
                res.red = '0;
                res.green = '0;
                res.blue = '0;
            end
        end
        if (fe) begin
            res.left_mean = roi_mean(lr, left_total);
            res.right_mean = roi_mean(rr, right_total);
            res.means_valid = 1'b1;
            left_total = '0;
            right_total = '0;
            frames_closed++;
        end
        pending_results.push_back(res);
    endtask

    // Present one pixel request and wait until it is taken.
    task automatic send_pixel(input int unsigned x, input int unsigned y,
                              input int unsigned r, input int unsigned g,
                              input int unsigned b, input bit fe);
        @(negedge i_clk);
        while (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.col       <= COORD_W'(x);
        pix_ch.row       <= COORD_W'(y);
        pix_ch.red_in    <= CH_W'(r);
        pix_ch.green_in  <= CH_W'(g);
        pix_ch.blue_in   <= CH_W'(b);
        pix_ch.frame_end <= fe;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        pixels_sent++;
        predict_pixel(x, y, CH_W'(r), CH_W'(g), CH_W'(b), fe);
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic wait_all_results();
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx < NUM_REGS) roi_regs[idx[RIDX_W-1:0]] = val;
    endtask

    // Program both rectangles; optionally also hit an index past the register file.
    task automatic set_rects(input t_rect l, input t_rect r, input bit poke_unused);
        write_reg(CFG_IDX_W'(REG_LEFT_X_LOW), l.x_low);
        write_reg(CFG_IDX_W'(REG_LEFT_X_HIGH), l.x_high);
        write_reg(CFG_IDX_W'(REG_LEFT_Y_LOW), l.y_low);
        write_reg(CFG_IDX_W'(REG_LEFT_Y_HIGH), l.y_high);
        write_reg(CFG_IDX_W'(REG_RIGHT_X_LOW), r.x_low);
        write_reg(CFG_IDX_W'(REG_RIGHT_X_HIGH), r.x_high);
        write_reg(CFG_IDX_W'(REG_RIGHT_Y_LOW), r.y_low);
        write_reg(CFG_IDX_W'(REG_RIGHT_Y_HIGH), r.y_high);
        if (poke_unused)
            write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_REGS)),
                      REG_W'($urandom));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic int unsigned pick_level();
        int unsigned p;
        p = $urandom_range(9);
        if (p == 0) return 0;
        if (p == 1) return 255;
        return $urandom_range(255);
    endfunction

    // A coordinate in or just around the span [lo, hi), kept inside the coordinate range.
    function automatic int unsigned coord_near(int lo, int hi);
        int a, b;
        a = lo - 3;
        b = hi + 2;
        if (a < 0) a = 0;
        if (a > 1023) a = 1023;
        if (b > 1023) b = 1023;
        if (b < a) b = a;
        return $urandom_range(b, a);
    endfunction

    // Mostly small valid rectangles, some against the frame limits, some broken.
    function automatic t_rect random_rect();
        int w, h, xl, yl, pick;
        w = $urandom_range(8, 1);
        h = $urandom_range(8, 1);
        pick = $urandom_range(99);
        if (pick < 50) begin
            xl = $urandom_range(FRAME_W - w, 0);
            yl = $urandom_range(FRAME_H - 1 - h, 0);
            return rect_of(xl, xl + w, yl, yl + h);
        end
        if (pick < 62) return rect_of(FRAME_W - w, FRAME_W, FRAME_H - 1 - h, FRAME_H - 1);
        if (pick < 72) return rect_of(0, w, 0, h);
        if (pick < 78) begin
            yl = $urandom_range(FRAME_H - 1 - h, 0);
            return rect_of(0, FRAME_W, yl, yl + h);
        end
        case ($urandom_range(4))
            0: return rect_of($urandom_range(2047), $urandom_range(2047),
                              $urandom_range(2047), $urandom_range(2047));
            1: return rect_of(w + 10, w + 10, 0, h);
            2: return rect_of(FRAME_W - w, FRAME_W + 1, 0, h);
            3: return rect_of(0, w, FRAME_H - h, FRAME_H);
            default: return rect_of(FRAME_W, FRAME_W + w, FRAME_H, FRAME_H + h);
        endcase
    endfunction

    // After reset both rectangles are empty, so nothing is blanked and means are zero.
    task automatic test_reset_defaults();
        send_pixel(0, 0, 255, 255, 255, 1'b1);
        send_pixel(1023, 1023, 0, 0, 0, 1'b0);
    endtask

    // Rectangles pressed against the far frame edges and against the origin.
    task automatic test_frame_edge_rects();
        wait_all_results();
        set_rects(rect_of(1020, 1024, 1019, 1023), rect_of(0, 4, 0, 4), 1'b1);
        send_pixel(1023, 1022, 255, 255, 255, 1'b0);
        send_pixel(1019, 1018, 255, 255, 255, 1'b0);
        send_pixel(1021, 1020, 10, 20, 30, 1'b0);
        send_pixel(0, 0, 255, 255, 255, 1'b0);
        send_pixel(3, 3, 7, 8, 9, 1'b0);
        send_pixel(1023, 1023, 200, 100, 50, 1'b0);
        send_pixel(2, 2, 1, 2, 3, 1'b1);
    endtask

    // The right rectangle encloses the left one and only sums what the left leaves unblanked.
    task automatic test_overlap_masking();
        wait_all_results();
        set_rects(rect_of(10, 20, 10, 20), rect_of(5, 30, 5, 30), 1'b0);
        send_pixel(10, 10, 100, 110, 120, 1'b0);
        send_pixel(15, 15, 200, 210, 220, 1'b0);
        send_pixel(6, 6, 50, 60, 70, 1'b0);
        send_pixel(25, 12, 90, 80, 70, 1'b1);
    endtask

    // A one-pixel rectangle hit three times drives the mean past the channel maximum.
    task automatic test_mean_clamp();
        wait_all_results();
        set_rects(rect_of(0, 1, 0, 1), rect_of(1000, 1025, 0, 5), 1'b0);
        send_pixel(0, 0, 255, 255, 255, 1'b0);
        send_pixel(0, 0, 255, 255, 255, 1'b0);
        send_pixel(0, 0, 255, 255, 255, 1'b1);
    endtask

    // Empty and out-of-frame rectangles neither sum nor blank.
    task automatic test_invalid_rects();
        wait_all_results();
        set_rects(rect_of(5, 5, 0, 10), rect_of(0, 10, 0, 1024), 1'b1);
        send_pixel(5, 5, 40, 50, 60, 1'b0);
        send_pixel(3, 3, 40, 50, 60, 1'b1);
        wait_all_results();
        set_rects(rect_of(1024, 1030, 0, 4), rect_of(2047, 2047, 2047, 2047), 1'b1);
        send_pixel(1023, 1, 11, 22, 33, 1'b1);
    endtask

    // Sums carry across a register change; the mean uses the rectangle in force at frame end.
    task automatic test_config_between_pixels();
        wait_all_results();
        set_rects(rect_of(100, 104, 100, 104), rect_of(200, 210, 200, 210), 1'b0);
        send_pixel(101, 101, 90, 90, 90, 1'b0);
        send_pixel(102, 102, 90, 90, 90, 1'b0);
        wait_all_results();
        set_rects(rect_of(100, 102, 100, 102), rect_of(200, 200, 200, 210), 1'b0);
        send_pixel(101, 101, 90, 90, 90, 1'b1);
    endtask

    // Phases of random rectangles, each followed by a random mix of raster frames, clustered frames and noise.
    task automatic test_random_frames();
        t_rect       lr;
        t_rect       rr;
        t_rect       aim;
        int unsigned phase, start, pick, n, k, x, y;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_all_results();
            gaps_on = !(phase >= 5 && phase <= 7);
            lr = random_rect();
            rr = random_rect();
            if ($urandom_range(3) == 0) begin
                rr = lr;
                rr.x_low  = lr.x_low + REG_W'($urandom_range(2));
                rr.x_high = lr.x_high + REG_W'($urandom_range(3));
            end
            set_rects(lr, rr, $urandom_range(3) == 0);
            start = pixels_sent;
            while (pixels_sent - start < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                aim = $urandom_range(1) ? lr : rr;
                if (pick < 35 && roi_usable(aim) &&
                    (aim.x_high - aim.x_low) * (aim.y_high - aim.y_low) <= RASTER_AREA) begin
                    // Full scan of the rectangle, closing the frame on its last pixel.
                    for (y = aim.y_low; y < aim.y_high; y++)
                        for (x = aim.x_low; x < aim.x_high; x++)
                            send_pixel(x, y, pick_level(), pick_level(), pick_level(),
                                       x == aim.x_high - 1 && y == aim.y_high - 1);
                end else if (pick < 80) begin
                    n = $urandom_range(30, 4);
                    for (k = 0; k < n; k++)
                        send_pixel(coord_near(aim.x_low, aim.x_high),
                                   coord_near(aim.y_low, aim.y_high),
                                   pick_level(), pick_level(), pick_level(), k == n - 1);
                end else begin
                    // Scattered pixels anywhere, with an occasional stray frame end.
                    n = $urandom_range(12, 1);
                    for (k = 0; k < n; k++)
                        send_pixel($urandom_range(1023), $urandom_range(1023),
                                   $urandom_range(255), $urandom_range(255),
                                   $urandom_range(255), $urandom_range(7) == 0);
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // Reset, then run the tests in turn and report.
    initial begin
        i_rst_n          = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        pix_ch.valid     = 1'b0;
        pix_ch.col       = '0;
        pix_ch.row       = '0;
        pix_ch.red_in    = '0;
        pix_ch.green_in  = '0;
        pix_ch.blue_in   = '0;
        pix_ch.frame_end = 1'b0;
        res_ch.ready     = 1'b0;
        gaps_on          = 1'b1;
        cycle_count      = 0;
        pixels_sent      = 0;
        results_seen     = 0;
        frames_closed    = 0;
        settings_used    = 0;
        mismatches       = 0;
        left_total       = '0;
        right_total      = '0;
        foreach (roi_regs[i]) roi_regs[i] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_frame_edge_rects();
        test_overlap_masking();
        test_mean_clamp();
        test_invalid_rects();
        test_config_between_pixels();
        test_random_frames();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d pixel requests under %0d rectangle settings, closing %0d frames.",
                 pixels_sent, settings_used, frames_closed);
        $display("Checked %0d results; %0d failed, %0d never arrived.",
                 results_seen, mismatches, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
